/* hdl/lrd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Logo RLE decoder package
// Shared types and constants for the run-length decoder front and back ends.
// ----------------------------------------------------------------------------
package lrd_pkg;

    localparam int unsigned COUNT_WIDTH_DEFAULT = 16;
    localparam logic [15:0] PIXEL_TOTAL_RESET   = 16'd33760;

    // Entries in the word queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Palette indexes
    localparam logic [1:0] COLOR_BLACK = 2'd0;
    localparam logic [1:0] COLOR_GRAY  = 2'd2;
    localparam logic [1:0] COLOR_WHITE = 2'd3;

    // Code byte fields and run lengths
    localparam logic [7:0] RUN_FLAG     = 8'h80;
    localparam logic [7:0] GRAY_FLAG    = 8'h40;
    localparam logic [7:0] LEN_EXT_HEAD = 8'd63;
    localparam logic [7:0] LEN_EXT_FULL = 8'd255;

    // Run step within one code word
    typedef enum logic [1:0] {
        STEP_FIRST  = 2'd0,
        STEP_SECOND = 2'd1,
        STEP_THIRD  = 2'd2
    } step_t;

    // Classified code word, as the front end hands it to the back end
    typedef struct packed {
        logic [7:0] code;
        logic       literal;    // top bit clear: three single pixels
        logic       len_zero;   // run header with zero length field
        logic       byte_zero;  // whole byte zero (extension: continue)
        logic       gray;       // trailing gray pixel requested
    } code_t;

endpackage

/* hdl/lrd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Logo RLE decoder front end
// Accepts code words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module lrd_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,     // [7:0] code_byte
    output logic           head_valid,
    output lrd_pkg::code_t head,
    input  logic           head_pop
);
    import lrd_pkg::*;

    code_t                 queue_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg;
    logic [QUEUE_CW-1:0]   count_next;
    logic                  push;
    logic                  pop;
    code_t                 classified;

    // Classify the incoming word
    always_comb
    begin
        classified.code      = s_tdata;
        classified.literal   = (s_tdata & RUN_FLAG) == 8'h00;
        classified.len_zero  = s_tdata[5:0] == 6'd0;
        classified.byte_zero = s_tdata == 8'h00;
        classified.gray      = (s_tdata & GRAY_FLAG) != 8'h00;
    end

    assign s_tready   = count_reg != QUEUE_CW'(QUEUE_DEPTH);
    assign push       = s_tvalid && s_tready;
    assign pop        = head_pop && head_valid;
    assign head_valid = count_reg != '0;
    assign head       = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= classified;
        end
    end

endmodule

/* hdl/lrd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Logo RLE decoder back end
// Expands queued code words into clipped runs, one run per cycle while a word is queued and the output is not stalled.
// ----------------------------------------------------------------------------
module lrd_back #(
    parameter int unsigned COUNT_WIDTH = lrd_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [15:0]    pixel_total,
    input  logic           head_valid,
    input  lrd_pkg::code_t head,
    output logic           head_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    m_tdata,     // [1:0] color, [9:2] run_length,
                                        // [25:10] start_pixel, [31:26] zero
    output logic           m_tuser,     // [0] frame_done
    output logic           m_tlast
);
    import lrd_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    step_t                  step_reg;
    step_t                  step_next;
    logic [1:0]             run_color_reg;
    logic [1:0]             run_color_next;
    logic                   in_ext_reg;
    logic                   in_ext_next;
    logic                   gray_pend_reg;
    logic                   gray_pend_next;
    logic [COUNT_WIDTH-1:0] counter_reg;
    logic [COUNT_WIDTH-1:0] counter_next;
    logic                   m_valid_reg;
    logic [31:0]            m_data_reg;
    logic                   m_user_reg;
    logic                   m_last_reg;

    logic [COUNT_WIDTH-1:0] frame_tot;
    logic [COUNT_WIDTH-1:0] room;
    logic                   full;
    logic                   fire;
    logic [1:0]             res_color;
    logic [7:0]             res_len;
    logic                   res_last;
    logic [7:0]             take;
    logic [15:0]            start_pix;

    // Clamp the frame total to what the counter can hold
    assign frame_tot = (32'(pixel_total) > 32'(COUNT_MAX)) ? COUNT_MAX
                                                           : COUNT_WIDTH'(pixel_total);
    assign full      = counter_reg >= frame_tot;
    assign room      = frame_tot - counter_reg;
    assign fire      = head_valid && (!m_valid_reg || m_tready);
    assign head_pop  = fire && res_last;
    assign start_pix = 16'(counter_reg);

    // Pick this step's run and the state left behind by the word
    always_comb
    begin
        res_color      = COLOR_BLACK;
        res_len        = 8'd0;
        res_last       = 1'b1;
        step_next      = STEP_FIRST;
        run_color_next = run_color_reg;
        in_ext_next    = in_ext_reg;
        gray_pend_next = gray_pend_reg;
        if (step_reg == STEP_FIRST && full)
        begin
            // Frame already full: drop the word, report an empty run
            res_color = COLOR_BLACK;
            res_len   = 8'd0;
        end
        else if (in_ext_reg)
        begin
            if (head.byte_zero)
            begin
                res_color = run_color_reg;
                res_len   = LEN_EXT_FULL;
            end
            else if (step_reg == STEP_FIRST)
            begin
                res_color = run_color_reg;
                res_len   = head.code;
                if (gray_pend_reg)
                begin
                    res_last  = 1'b0;
                    step_next = STEP_SECOND;
                end
                else
                begin
                    in_ext_next    = 1'b0;
                    gray_pend_next = 1'b0;
                    run_color_next = run_color_reg ^ COLOR_WHITE;
                end
            end
            else
            begin
                res_color      = COLOR_GRAY;
                res_len        = 8'd1;
                in_ext_next    = 1'b0;
                gray_pend_next = 1'b0;
                run_color_next = run_color_reg ^ COLOR_WHITE;
            end
        end
        else if (head.literal)
        begin
            res_len = 8'd1;
            case (step_reg)
                STEP_FIRST:
                begin
                    res_color = head.code[6:5];
                    res_last  = 1'b0;
                    step_next = STEP_SECOND;
                end
                STEP_SECOND:
                begin
                    res_color = head.code[4:3];
                    res_last  = 1'b0;
                    step_next = STEP_THIRD;
                end
                default:
                begin
                    res_color      = head.code[2:1];
                    run_color_next = head.code[0] ? COLOR_WHITE : COLOR_BLACK;
                end
            endcase
        end
        else if (head.len_zero)
        begin
            res_color      = run_color_reg;
            res_len        = LEN_EXT_HEAD;
            in_ext_next    = 1'b1;
            gray_pend_next = head.gray;
        end
        else if (step_reg == STEP_FIRST)
        begin
            res_color = run_color_reg;
            res_len   = {2'b00, head.code[5:0]};
            if (head.gray)
            begin
                res_last  = 1'b0;
                step_next = STEP_SECOND;
            end
            else
            begin
                in_ext_next    = 1'b0;
                gray_pend_next = 1'b0;
                run_color_next = run_color_reg ^ COLOR_WHITE;
            end
        end
        else
        begin
            res_color      = COLOR_GRAY;
            res_len        = 8'd1;
            in_ext_next    = 1'b0;
            gray_pend_next = 1'b0;
            run_color_next = run_color_reg ^ COLOR_WHITE;
        end
    end

    // Clip the run to the pixels left in the frame
    always_comb
    begin
        if (full)
        begin
            take = 8'd0;
        end
        else if (room < COUNT_WIDTH'(res_len))
        begin
            take = room[7:0];
        end
        else
        begin
            take = res_len;
        end
        counter_next = counter_reg + COUNT_WIDTH'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_FIRST;
            run_color_reg <= COLOR_BLACK;
            in_ext_reg    <= 1'b0;
            gray_pend_reg <= 1'b0;
            counter_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                step_reg      <= step_next;
                run_color_reg <= run_color_next;
                in_ext_reg    <= in_ext_next;
                gray_pend_reg <= gray_pend_next;
                counter_reg   <= counter_next;
                m_valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            m_data_reg <= {6'd0, start_pix, take, res_color};
            m_user_reg <= counter_next >= frame_tot;
            m_last_reg <= res_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // A word being expanded stays at the queue head until its last run
    a_step_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != STEP_FIRST |-> head_valid)
        else $error("back end mid-word without a queued word");

    // Only a literal reaches its third run
    a_third_step_literal: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == STEP_THIRD |-> (head.literal && !in_ext_reg))
        else $error("third run step on a non-literal word");

    // The pixel counter only moves forward
    a_counter_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> counter_reg >= $past(counter_reg))
        else $error("pixel counter went backward");

endmodule

/* hdl/logo_rle_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Logo RLE decoder
// Expands a run-length coded 2-bit palette image into colored pixel runs.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one compressed code byte per word in s_tdata[7:0].
//   Output stream (m_*): one run per word: color, run_length and start_pixel
//   in m_tdata, frame_done in m_tuser, and m_tlast on the final run that a
//   code byte produces. A literal byte gives three runs, a run header one or
//   two (trailing gray), an extension byte one or two.
//   Configuration: pulse cfg_we with cfg_wdata to set pixel_total; write it
//   only while no byte is in flight.
// Timing:
//   An accepted byte is queued, and each of its runs is then registered in
//   the output register before it can be taken. The back end emits one run
//   per cycle while a byte is queued and the output is not stalled; a byte
//   yields one to three runs, set by the single run expander.
//   A two-word queue separates input and expander, so bytes keep flowing in
//   while runs are still being emitted.
// Reset and stall:
//   Reset clears the queue, the run color (black), the extension and gray
//   flags and the pixel counter, and loads pixel_total with 33760.
//   When m_tready is low the output word holds; the queue fills and then
//   s_tready drops. Once the frame is full each byte yields one empty run.
// ----------------------------------------------------------------------------
module logo_rle_decoder #(
    parameter int unsigned COUNT_WIDTH = lrd_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] code_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [1:0] color, [9:2] run_length,
                                    // [25:10] start_pixel, [31:26] zero
    output logic        m_tuser,    // [0] frame_done
    output logic        m_tlast,    // last run of this code byte
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata   // pixel_total
);
    import lrd_pkg::*;

    logic [15:0] pixel_total_reg;
    logic        head_valid;
    code_t       head;
    logic        head_pop;

    // Hold the frame size; the back end compares against it on every run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_total_reg <= PIXEL_TOTAL_RESET;
        end
        else if (cfg_we)
        begin
            pixel_total_reg <= cfg_wdata;
        end
    end

    // Accept and classify code bytes, queue them
    lrd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    // Expand queued bytes into clipped runs
    lrd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_total (pixel_total_reg),
        .head_valid  (head_valid),
        .head        (head),
        .head_pop    (head_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

/* test/logo_rle_decoder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Logo RLE decoder testbench
// Streams code bytes into the decoder under random source gaps and sink
// stalls. A scoreboard predicts every run word from the code bytes and the
// frame size, and checks each output word in order. The frame size moves
// through its extremes between phases.
// ----------------------------------------------------------------------------
module logo_rle_decoder_test;

    import lrd_pkg::*;

    // Longest stretch without any handshake before the run is declared hung.
    // The slowest correct case is the longest source gap on top of the longest
    // sink stall plus the decoder's own latency.
    localparam int unsigned IDLE_LIMIT   = 1000;
    // Cycles to keep watching the output after the last expected word
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam logic [15:0] TOTAL_MAX    = 16'hFFFF;
    localparam logic [15:0] TOTAL_NONE   = 16'd0;
    localparam logic [15:0] TOTAL_ONE    = 16'd1;

    // One run as the decoder reports it
    typedef struct packed {
        logic [1:0]  color;
        logic [7:0]  run_length;
        logic [15:0] start_pixel;
        logic        frame_done;
        logic        last;
    } run_t;

    // ------------------------------------------------------------------------
    // Run tracker: mirrors the decoder state, turns each accepted code byte
    // into the runs it must produce, and checks output words in order.
    // ------------------------------------------------------------------------
    class run_tracker;
        logic [15:0] pixel_total;
        logic [1:0]  run_color;
        logic        in_ext;
        logic        gray_due;
        int unsigned pixels_used;
        int unsigned failures;
        run_t        expected_runs[$];

        function new();
            pixel_total = PIXEL_TOTAL_RESET;
            run_color   = COLOR_BLACK;
            in_ext      = 1'b0;
            gray_due    = 1'b0;
            pixels_used = 0;
            failures    = 0;
        endfunction

        function void set_total(logic [15:0] value);
            pixel_total = value;
        endfunction

        // The counter is as wide as the register, so the total never needs
        // clamping to the counter range.
        function bit frame_full();
            return pixels_used >= pixel_total;
        endfunction

        // Queue one run, clipped to the pixels left in the frame
        function void add_run(logic [1:0] color, int unsigned len);
            int unsigned room;
            int unsigned take;
            run_t        r;
            room          = frame_full() ? 0 : pixel_total - pixels_used;
            take          = (len < room) ? len : room;
            r.color       = color;
            r.run_length  = 8'(take);
            r.start_pixel = 16'(pixels_used);
            pixels_used   = pixels_used + take;
            r.frame_done  = frame_full();
            r.last        = 1'b0;
            expected_runs.insert(expected_runs.size(), r);
        endfunction

        // A finished run drops the extension and gray flags and flips the
        // run color between black and white.
        function void end_run();
            in_ext    = 1'b0;
            gray_due  = 1'b0;
            run_color = (run_color == COLOR_WHITE) ? COLOR_BLACK : COLOR_WHITE;
        endfunction

        function void take_code(logic [7:0] code);
            logic gray;
            if (frame_full())
            begin
                // full frame: byte is dropped, one empty black run
                add_run(COLOR_BLACK, 0);
            end
            else if (in_ext)
            begin
                if (code == 8'd0)
                begin
                    add_run(run_color, LEN_EXT_FULL);
                end
                else
                begin
                    gray = gray_due;
                    add_run(run_color, code);
                    if (gray)
                        add_run(COLOR_GRAY, 1);
                    end_run();
                end
            end
            else if ((code & RUN_FLAG) == 8'd0)
            begin
                // literal: three single pixels, bit 0 picks the next run color
                add_run(code[6:5], 1);
                add_run(code[4:3], 1);
                add_run(code[2:1], 1);
                run_color = code[0] ? COLOR_WHITE : COLOR_BLACK;
            end
            else
            begin
                gray = (code & GRAY_FLAG) != 8'd0;
                if (code[5:0] == 6'd0)
                begin
                    add_run(run_color, LEN_EXT_HEAD);
                    in_ext   = 1'b1;
                    gray_due = gray;
                end
                else
                begin
                    add_run(run_color, code[5:0]);
                    if (gray)
                        add_run(COLOR_GRAY, 1);
                    end_run();
                end
            end
            expected_runs[expected_runs.size() - 1].last = 1'b1;
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                failures++;
                $error("%s: expected %0d, actual %0d", name, want, got);
            end
        endfunction

        function void check_run(logic [31:0] data, logic done, logic last_flag);
            run_t want;
            if (expected_runs.size() == 0)
            begin
                failures++;
                $error("run word with nothing expected: tdata %h", data);
                return;
            end
            want = expected_runs.pop_front();
            check_field("color", want.color, data[1:0]);
            check_field("run_length", want.run_length, data[9:2]);
            check_field("start_pixel", want.start_pixel, data[25:10]);
            check_field("frame_done", want.frame_done, done);
            check_field("last", want.last, last_flag);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals and instance
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // [7:0] code_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;      // [1:0] color, [9:2] run_length, [25:10] start_pixel
    logic        m_tuser;      // [0] frame_done
    logic        m_tlast;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    run_tracker  tracker;
    bit          steady       = 1'b0;   // suppress all gaps and stalls
    int unsigned codes_sent   = 0;
    int unsigned idle_cycles  = 0;

    logo_rle_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length for source and sink: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: note every accepted code byte, then check every accepted run
    // word. Both are sampled at the same edge, so order inside a step does
    // not matter; a run word is always taken after its byte, never at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                tracker.take_code(s_tdata);
            if (m_tvalid && m_tready)
                tracker.check_run(m_tdata, m_tuser, m_tlast);
        end
    end

    // Watchdog: end the run when no handshake happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sink: alternate ready stretches with random stalls. Lower ready only
    // when the stall is nonzero, so ready never drops and rises in one step.
    initial
    begin
        int unsigned stall;
        m_tready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall = pick_gap();
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Offer one code byte after a random gap and hold it until accepted.
    // Valid stays high into the next byte when there is no gap.
    task automatic send_code(input logic [7:0] code);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        do @(posedge clk); while (!s_tready);
        codes_sent++;
    endtask

    // Drop valid, let the monitor note the last byte, then wait until every
    // expected run word has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_runs.size() != 0)
            @(posedge clk);
    endtask

    // Pulse the frame size register; the decoder is idle here
    task automatic write_total(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tracker.set_total(value);
    endtask

    // One well-formed group of random content, now and then a random byte.
    // Extension groups open with a zero-length header, carry up to two
    // continue bytes and close with a nonzero byte.
    task automatic send_random_group();
        int unsigned r;
        int unsigned k;
        logic [7:0]  head;
        r    = $urandom_range(0, 99);
        head = $urandom_range(0, 1) ? (RUN_FLAG | GRAY_FLAG) : RUN_FLAG;
        if (r < 35)
        begin
            send_code(8'($urandom_range(0, 127)));
        end
        else if (r < 70)
        begin
            send_code(head | 8'($urandom_range(1, 63)));
        end
        else if (r < 88)
        begin
            send_code(head);
            k = $urandom_range(0, 2);
            repeat (k) send_code(8'd0);
            send_code(8'($urandom_range(1, 255)));
        end
        else
        begin
            send_code(8'($urandom_range(0, 255)));
        end
    endtask

    // Random groups until n more bytes have gone in; every ten groups pick
    // again whether the next stretch runs with no gaps at all.
    task automatic run_random(input int unsigned n);
        int unsigned first;
        int unsigned groups;
        first  = codes_sent;
        groups = 0;
        while (codes_sent - first < n)
        begin
            if (groups % 10 == 0)
                steady = ($urandom_range(0, 3) == 0);
            send_random_group();
            groups++;
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        tracker = new();
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 16'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One-pixel frame: the first literal fills it, its other two pixels
        // clip to empty runs, and the next byte is dropped.
        write_total(TOTAL_ONE);
        send_code(8'h00);
        send_code(8'hFF);
        drain();

        // Largest frame reopens the full frame; walk every byte kind
        write_total(TOTAL_MAX);
        send_code(8'h7F);      // literal, all white, next run white
        send_code(8'h2A);      // literal, all color index 1, next run black
        send_code(8'h54);      // literal, all gray
        send_code(8'h81);      // one-pixel run
        send_code(8'hBF);      // 63-pixel run
        send_code(8'hC5);      // run plus trailing gray
        send_code(8'hFF);      // longest header run plus gray
        send_code(8'h80);      // zero length: 63 and extension follows
        send_code(8'h00);      // continue with 255
        send_code(8'h00);
        send_code(8'hFF);      // close with 255
        send_code(8'hC0);      // extension with gray pending
        send_code(8'h01);      // close with one pixel, then gray
        send_code(8'hC0);
        send_code(8'h00);
        send_code(8'h80);      // close byte with top bit set is a length
        send_code(8'h40);      // literal with top pixel gray
        send_code(8'h55);      // literal, next run white
        send_code(8'h9E);      // run in white
        drain();

        run_random(55);
        drain();

        // Small room left: runs clip at the frame end, later bytes dropped
        write_total(16'(tracker.pixels_used + $urandom_range(20, 80)));
        run_random(25);
        drain();

        // Empty frame: full at once
        write_total(TOTAL_NONE);
        send_code(8'h2B);
        send_code(8'hC3);
        send_code(8'h80);
        drain();

        write_total(TOTAL_MAX);
        run_random(60);
        drain();

        // Catch any stray word after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.failures == 0 && tracker.expected_runs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
hdl/lrd_pkg.sv
hdl/lrd_front.sv
hdl/lrd_back.sv
hdl/logo_rle_decoder.sv
test/logo_rle_decoder_test.sv
